// ----- src/pgn_pkg.sv -----
`default_nettype none

package pgn_pkg;

  // Permutation table geometry (depth must be a power of two)
  localparam int TABLE_SIZE = 256;
  localparam int TBL_AW     = $clog2(TABLE_SIZE);
  localparam int ENTRY_W    = 8;
  localparam int INDEX_W    = 8;

  // Field and datapath widths
  localparam int COORD_W = 32;
  localparam int FREQ_W  = 24;
  localparam int FRAC_W  = 16;
  localparam int FADE_W  = FRAC_W + 1;
  localparam int OFS_W   = FRAC_W + 1;
  localparam int GRAD_W  = OFS_W + 2;
  localparam int NOISE_W = 18;

  // Shared multiplier operand and product widths
  localparam int MUL_AW = COORD_W + 1;
  localparam int MUL_BW = FREQ_W + 1;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = FREQ_W;

  typedef enum logic [CFG_AW-1:0] {
    REG_FREQUENCY  = 2'd0,
    REG_SEED_BITS  = 2'd1,
    REG_DIMENSIONS = 2'd2,
    REG_UNIT_RANGE = 2'd3
  } cfg_reg_t;

  // Improved-noise gradient: pick two of the three offsets by the hash
  // and negate each by one hash bit.
  function automatic logic signed [GRAD_W-1:0] gradient(
    input logic [3:0]               h,
    input logic signed [OFS_W-1:0]  x,
    input logic signed [OFS_W-1:0]  y,
    input logic signed [OFS_W-1:0]  z
  );
    logic signed [GRAD_W-1:0] u;
    logic signed [GRAD_W-1:0] v;
    u = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
    if (h < 4'd4) begin
      v = GRAD_W'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      v = GRAD_W'(x);
    end else begin
      v = GRAD_W'(z);
    end
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

endpackage

`default_nettype wire

// ----- src/pgn_table.sv -----
`default_nettype none

module pgn_table import pgn_pkg::*; (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [TBL_AW-1:0]  wr_addr,
  input  wire logic [ENTRY_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [TBL_AW-1:0]  rd_addr,
  output logic      [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/pgn_mul.sv -----
`default_nettype none

module pgn_mul import pgn_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [MUL_AW-1:0] op_a,
  input  wire logic signed [MUL_BW-1:0] op_b,
  output logic      signed [MUL_PW-1:0] prod
);

  logic signed [MUL_PW-1:0] full;

  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    prod <= full;
  end

endmodule

`default_nettype wire

// ----- src/perlin_gradient_noise_unit.sv -----
// Gradient noise unit, 1D/2D/3D, signed Q16.16 coordinates in, signed Q2.16 out.
// Input channel: in_valid/in_stall. A transaction with mode 0 writes one
// permutation entry (table_index, table_value) and produces nothing. A
// transaction with mode 1 evaluates the noise at (coord_x, coord_y, coord_z)
// and produces one noise_value on the output channel.
// Every table entry that a point touches must have been loaded first.
// Configuration: cfg_valid/cfg_ready with cfg_index 0..3 = frequency,
// seed_bits, dimensions, unit_range; cfg_ready is always high. Write only
// while no point is in flight.
// in_stall is high while a point is being computed and drops in the cycle
// in which the result is written to the output register. A point runs through
// one shared registered multiplier (4 products per axis for scale and fade,
// one per blend, each blend a subtract, multiply and add step) and the table
// read chain on its one read port (2 + 4 + 8 reads in 3D, one wait per level).
// The result sits in an output register; while out_stall is high it holds,
// and the unit keeps accepting loads and may compute the next point, which
// then waits until the register is free.
// Synchronous reset restores the register defaults (frequency 1.0, seed 0,
// 3D, signed range) and empties the pipeline; table contents are not cleared.
`default_nettype none

module perlin_gradient_noise_unit import pgn_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      mode,
  input  wire logic        [INDEX_W-1:0] table_index,
  input  wire logic        [ENTRY_W-1:0] table_value,
  input  wire logic signed [COORD_W-1:0] coord_x,
  input  wire logic signed [COORD_W-1:0] coord_y,
  input  wire logic signed [COORD_W-1:0] coord_z,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed      [NOISE_W-1:0] noise_value,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic        [CFG_AW-1:0]  cfg_index,
  input  wire logic        [CFG_DW-1:0]  cfg_data
);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(65536);
  localparam logic [1:0]        DIM_RESET  = 2'd3;

  localparam int Q_W   = 23;
  localparam int QR_W  = 20;
  localparam int SUM_W = GRAD_W + 2;
  // 10.0 in Q16 for the fade polynomial
  localparam logic [Q_W-1:0] Q_BIAS = Q_W'(655360);

  localparam logic signed [GRAD_W-1:0] HALF_ONE  = GRAD_W'(32768);
  localparam logic signed [GRAD_W-1:0] NOISE_MAX = GRAD_W'((1 << (NOISE_W - 1)) - 1);
  localparam logic signed [GRAD_W-1:0] NOISE_MIN = -GRAD_W'(1 << (NOISE_W - 1));

  typedef enum logic [3:0] {
    S_IDLE,
    S_AX_MUL,
    S_AX_T,
    S_AX_S,
    S_AX_C,
    S_AX_F,
    S_HRD,
    S_HWAIT,
    S_GRAD,
    S_LSUB,
    S_LMUL,
    S_LADD,
    S_FIN
  } state_t;

  state_t state;

  // Configuration registers
  logic [FREQ_W-1:0] frequency;
  logic [3:0]        seed_bits;
  logic [1:0]        dimensions;
  logic              unit_range;

  // Per-point working registers
  logic [1:0]                  dim;
  logic signed [COORD_W-1:0]   coord [3];
  logic [1:0]                  ax;
  logic [FRAC_W-1:0]           t_ax [3];
  logic [TBL_AW-1:0]           cell_ax [3];
  logic [FADE_W-1:0]           fade [3];
  logic [FRAC_W-1:0]           t_cur;
  logic [QR_W-1:0]             q_reg;

  logic [1:0]                  level;
  logic [2:0]                  hj;
  logic                        rd_pend;
  logic [2:0]                  rd_j;
  logic [ENTRY_W-1:0]          hv [8];
  logic [ENTRY_W-1:0]          hn [8];

  logic signed [GRAD_W-1:0]    va [8];
  logic [3:0]                  lq_cnt;
  logic signed [GRAD_W-1:0]    a_reg;
  logic signed [GRAD_W:0]      diff_reg;
  logic [FADE_W-1:0]           f_reg;
  logic signed [GRAD_W-1:0]    val;

  // Shared multiplier and table
  logic signed [MUL_AW-1:0]    op_a;
  logic signed [MUL_BW-1:0]    op_b;
  logic signed [MUL_PW-1:0]    prod;
  logic                        tbl_wr;
  logic                        tbl_rd;
  logic [TBL_AW-1:0]           rd_addr;
  logic [ENTRY_W-1:0]          rd_data;

  // Combinational helpers
  logic [FRAC_W-1:0]           prod_frac;
  logic [TBL_AW-1:0]           prod_cell;
  logic [FADE_W-1:0]           prod_fade;
  logic [Q_W-1:0]              q_calc;
  logic [2:0]                  hj_last;
  logic [1:0]                  lvl_bits;
  logic [1:0]                  lerp_ax;
  logic signed [SUM_W-1:0]     lerp_sum;
  logic signed [GRAD_W-1:0]    lerp_res;
  logic signed [GRAD_W-1:0]    remap;
  logic signed [GRAD_W-1:0]    sat;
  logic signed [OFS_W-1:0]     ofs_x [8];
  logic signed [OFS_W-1:0]     ofs_y [8];
  logic signed [OFS_W-1:0]     ofs_z [8];

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign tbl_wr = in_valid && !in_stall && (mode == MODE_LOAD);
  assign tbl_rd = (state == S_HRD);

  pgn_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (TBL_AW'(table_index)),
    .wr_data (table_value),
    .rd_en   (tbl_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pgn_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign prod_frac = prod[FRAC_W +: FRAC_W];
  assign prod_cell = prod[2*FRAC_W +: TBL_AW];
  assign prod_fade = prod[FRAC_W +: FADE_W];

  // 6s - 15t + 10, with s in prod_frac
  assign q_calc = Q_W'({prod_frac, 2'b00}) + Q_W'({prod_frac, 1'b0})
                - Q_W'({t_cur, 4'b0000}) + Q_W'(t_cur) + Q_BIAS;

  assign hj_last = 3'((4'd1 << level) - 4'd1);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_AX_MUL: begin
        op_a = MUL_AW'(coord[ax]);
        op_b = MUL_BW'(frequency);
      end
      S_AX_T: begin
        op_a = MUL_AW'(prod_frac);
        op_b = MUL_BW'(prod_frac);
      end
      S_AX_S: begin
        op_a = MUL_AW'(prod_frac);
        op_b = MUL_BW'(t_cur);
      end
      S_AX_C: begin
        op_a = MUL_AW'(prod_frac);
        op_b = MUL_BW'(q_reg);
      end
      S_LMUL: begin
        op_a = MUL_AW'(diff_reg);
        op_b = MUL_BW'(f_reg);
      end
      default: ;
    endcase
  end

  // Level L reads entry (previous hash of lower corner bits) + cell + top corner bit
  always_comb begin
    case (level)
      2'd1:    rd_addr = cell_ax[0] + TBL_AW'(hj);
      2'd2:    rd_addr = TBL_AW'(hv[{2'b00, hj[0]}]) + cell_ax[1] + TBL_AW'(hj[1]);
      default: rd_addr = TBL_AW'(hv[{1'b0, hj[1:0]}]) + cell_ax[2] + TBL_AW'(hj[2]);
    endcase
  end

  // Corner offsets: bit k of the corner number selects t - 1 on axis k
  always_comb begin
    logic [2:0] corner;
    for (int i = 0; i < 8; i++) begin
      corner   = 3'(i);
      ofs_x[i] = $signed({corner[0], t_ax[0]});
      ofs_y[i] = (dim >= 2'd2) ? $signed({corner[1], t_ax[1]}) : '0;
      ofs_z[i] = (dim == 2'd3) ? $signed({corner[2], t_ax[2]}) : '0;
    end
  end

  // Queue depth before a pop tells which axis this blend belongs to
  assign lvl_bits = (lq_cnt > 4'd4) ? 2'd3 : ((lq_cnt > 4'd2) ? 2'd2 : 2'd1);
  assign lerp_ax  = dim - lvl_bits;

  assign lerp_sum = SUM_W'(a_reg) + $signed(prod[FRAC_W +: SUM_W]);
  assign lerp_res = lerp_sum[GRAD_W-1:0];

  always_comb begin
    remap = unit_range ? ((val >>> 1) + HALF_ONE) : val;
    if (remap > NOISE_MAX) begin
      sat = NOISE_MAX;
    end else if (remap < NOISE_MIN) begin
      sat = NOISE_MIN;
    end else begin
      sat = remap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      frequency  <= FREQ_RESET;
      seed_bits  <= '0;
      dimensions <= DIM_RESET;
      unit_range <= 1'b0;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_FREQUENCY:  frequency  <= cfg_data[FREQ_W-1:0];
          REG_SEED_BITS:  seed_bits  <= cfg_data[3:0];
          REG_DIMENSIONS: dimensions <= cfg_data[1:0];
          REG_UNIT_RANGE: unit_range <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      rd_pend <= 1'b0;
      if (rd_pend) begin
        hn[rd_j] <= rd_data;
      end

      case (state)
        S_IDLE: begin
          if (in_valid && mode == MODE_POINT) begin
            coord[0] <= coord_x;
            coord[1] <= coord_y;
            coord[2] <= coord_z;
            dim      <= (dimensions == 2'd0) ? 2'd1 : dimensions;
            ax       <= 2'd0;
            state    <= S_AX_MUL;
          end
        end
        S_AX_MUL: state <= S_AX_T;
        S_AX_T: begin
          t_cur       <= prod_frac;
          t_ax[ax]    <= prod_frac;
          cell_ax[ax] <= prod_cell;
          state       <= S_AX_S;
        end
        S_AX_S: begin
          q_reg <= q_calc[Q_W-1] ? '0 : q_calc[QR_W-1:0];
          state <= S_AX_C;
        end
        S_AX_C: state <= S_AX_F;
        S_AX_F: begin
          fade[ax] <= prod_fade;
          if (ax == dim - 2'd1) begin
            level <= 2'd1;
            hj    <= '0;
            state <= S_HRD;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_AX_MUL;
          end
        end
        S_HRD: begin
          rd_pend <= 1'b1;
          rd_j    <= hj;
          if (hj == hj_last) begin
            state <= S_HWAIT;
          end else begin
            hj <= hj + 3'd1;
          end
        end
        S_HWAIT: begin
          // Promote this level's hashes, merging the read still in flight
          for (int i = 0; i < 8; i++) begin
            hv[i] <= (rd_pend && rd_j == 3'(i)) ? rd_data : hn[i];
          end
          if (level == dim) begin
            state <= S_GRAD;
          end else begin
            level <= level + 2'd1;
            hj    <= '0;
            state <= S_HRD;
          end
        end
        S_GRAD: begin
          for (int i = 0; i < 8; i++) begin
            va[i] <= gradient(hv[i][3:0] ^ seed_bits, ofs_x[i], ofs_y[i], ofs_z[i]);
          end
          lq_cnt <= 4'd1 << dim;
          state  <= S_LSUB;
        end
        S_LSUB: begin
          // Pop the front pair of the blend queue
          a_reg    <= va[0];
          diff_reg <= (GRAD_W+1)'(va[1]) - (GRAD_W+1)'(va[0]);
          f_reg    <= fade[lerp_ax];
          for (int i = 0; i < 6; i++) begin
            va[i] <= va[i+2];
          end
          lq_cnt <= lq_cnt - 4'd2;
          state  <= S_LMUL;
        end
        S_LMUL: state <= S_LADD;
        S_LADD: begin
          // Push the blend result at the tail
          va[lq_cnt[2:0]] <= lerp_res;
          lq_cnt          <= lq_cnt + 4'd1;
          if (lq_cnt == 4'd0) begin
            val   <= lerp_res;
            state <= S_FIN;
          end else begin
            state <= S_LSUB;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            noise_value <= NOISE_W'(sat);
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_hwait_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_HWAIT |-> rd_pend)
    else $error("level end without a table read in flight");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    state == S_AX_MUL |-> ax < dim)
    else $error("axis counter beyond point dimensions");

  a_blend_axis: assert property (@(posedge clk) disable iff (rst)
    state == S_LSUB |-> (lerp_ax < dim && lq_cnt >= 4'd2))
    else $error("blend queue out of step with dimensions");

  a_fin_single: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> lq_cnt == 4'd1)
    else $error("blend queue not reduced to one value");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside the finish step");

endmodule

`default_nettype wire

// ----- sim/perlin_gradient_noise_unit_test.sv -----
`timescale 1ns / 1ps

module perlin_gradient_noise_unit_test;
  import pgn_pkg::*;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  localparam int ONE_Q16      = 65536;
  localparam int SETTLE_TICKS = 80;      // beyond the 3D point latency
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 90;
  localparam int NUM_PHASES   = 9;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic                       mode;
    logic        [INDEX_W-1:0]  idx;
    logic        [ENTRY_W-1:0]  val;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic                       has_want;
    logic signed [NOISE_W-1:0]  want;
  } stim_row_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [3:0]        seed;
    logic [1:0]        dims;
    logic              unit;
    logic              roll;   // draw frequency and seed at random
  } phase_setup_t;

  typedef struct {
    logic [TBL_AW-1:0] base;
    longint            frac;
    longint            fade;
  } lattice_t;

  localparam int NUM_DIRECTED = 18;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{MODE_LOAD,  8'd0,   8'd255, 32'h0,        32'h0,        32'h0,        1'b0, 18'sd0},
    '{MODE_LOAD,  8'd255, 8'd0,   32'h0,        32'h0,        32'h0,        1'b0, 18'sd0},
    '{MODE_LOAD,  8'hAA,  8'h55,  32'h0,        32'h0,        32'h0,        1'b0, 18'sd0},
    '{MODE_LOAD,  8'h55,  8'hAA,  32'h0,        32'h0,        32'h0,        1'b0, 18'sd0},
    '{MODE_POINT, 8'd0,   8'd0,   32'h0,        32'h0,        32'h0,        1'b1, 18'sd0},
    '{MODE_POINT, 8'd0,   8'd0,   32'h00010000, 32'hFFFF0000, 32'h00020000, 1'b1, 18'sd0},
    '{MODE_POINT, 8'd0,   8'd0,   32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 18'sd0},
    '{MODE_POINT, 8'd0,   8'd0,   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 18'sd0},
    '{MODE_POINT, 8'd0,   8'd0,   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 18'sd0},
    '{MODE_POINT, 8'd0,   8'd0,   32'h7FFFFFFF, 32'h80000000, 32'h0,        1'b0, 18'sd0},
    '{MODE_POINT, 8'd0,   8'd0,   32'h00008000, 32'h00008000, 32'h00008000, 1'b0, 18'sd0},
    '{MODE_POINT, 8'd0,   8'd0,   32'h00014000, 32'hFFFF0C00, 32'h0003A000, 1'b0, 18'sd0},
    '{MODE_LOAD,  8'd255, 8'd255, 32'h0,        32'h0,        32'h0,        1'b0, 18'sd0},
    '{MODE_LOAD,  8'd0,   8'd0,   32'h0,        32'h0,        32'h0,        1'b0, 18'sd0},
    '{MODE_POINT, 8'd0,   8'd0,   32'h0000FFFF, 32'h00010001, 32'hFFFFFFFF, 1'b0, 18'sd0},
    '{MODE_POINT, 8'd255, 8'd255, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 1'b0, 18'sd0},
    '{MODE_POINT, 8'd0,   8'd0,   32'h7FFF0000, 32'h80010000, 32'h0,        1'b1, 18'sd0},
    '{MODE_POINT, 8'd0,   8'd0,   32'h00000001, 32'h0,        32'h0,        1'b0, 18'sd0}
  };

  localparam phase_setup_t PHASE_SETUP [NUM_PHASES] = '{
    '{24'd65536,    4'd0,  2'd3, 1'b0, 1'b0},
    '{24'hFFFFFF,   4'd15, 2'd3, 1'b1, 1'b0},
    '{24'd0,        4'd5,  2'd3, 1'b0, 1'b0},
    '{24'd65536,    4'd10, 2'd1, 1'b0, 1'b0},
    '{24'd0,        4'd0,  2'd0, 1'b1, 1'b1},
    '{24'd32768,    4'd9,  2'd2, 1'b0, 1'b0},
    '{24'hFFFFFF,   4'd0,  2'd2, 1'b1, 1'b0},
    '{24'd0,        4'd0,  2'd1, 1'b1, 1'b1},
    '{24'd196608,   4'd3,  2'd3, 1'b0, 1'b0}
  };

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic                       mode;
  logic        [INDEX_W-1:0]  table_index;
  logic        [ENTRY_W-1:0]  table_value;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic signed [COORD_W-1:0]  coord_z;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [NOISE_W-1:0]  noise_value;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic        [CFG_AW-1:0]   cfg_index;
  logic        [CFG_DW-1:0]   cfg_data;

  // Shadow copy of the block's table and configuration registers
  logic [ENTRY_W-1:0] shadow_perm [TABLE_SIZE];
  logic [FREQ_W-1:0]  freq_q;
  logic [3:0]         seed_q;
  logic [1:0]         dims_q;
  logic               unit_q;

  logic signed [NOISE_W-1:0] noise_due [$];
  logic signed [NOISE_W-1:0] due_head;
  int  fail_count = 0;
  int  free_items = 0;
  bit  calm = 1'b0;
  bit  long_hold_req = 1'b0;

  perlin_gradient_noise_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .table_index (table_index),
    .table_value (table_value),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .noise_value (noise_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic lattice_t split_axis(logic signed [COORD_W-1:0] coord);
    lattice_t r;
    longint   prod;
    longint   t;
    longint   s;
    longint   cube;
    longint   q;
    prod   = longint'(coord) * longint'(freq_q);
    r.base = prod[39:32];
    t      = longint'(prod[31:16]);
    s      = (t * t) >>> 16;
    cube   = (s * t) >>> 16;
    q      = 6 * s - 15 * t + 10 * ONE_Q16;
    if (q < 0) q = 0;
    r.frac = t;
    r.fade = (cube * q) >>> 16;
    return r;
  endfunction

  function automatic longint grad_term(logic [ENTRY_W-1:0] hash, longint x, longint y,
                                       longint z);
    logic [3:0] h;
    longint     u;
    longint     v;
    h = hash[3:0] ^ seed_q;
    u = (h < 4'd8) ? x : y;
    if (h < 4'd4) v = y;
    else if (h == 4'd12 || h == 4'd14) v = x;
    else v = z;
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  // Arithmetic shift floors the weighted difference
  function automatic longint lerp_q16(longint a, longint b, longint f);
    return a + ((f * (b - a)) >>> 16);
  endfunction

  function automatic logic [ENTRY_W-1:0] perm(logic [TBL_AW-1:0] i);
    return shadow_perm[i];
  endfunction

  function automatic logic signed [NOISE_W-1:0] noise_at(logic signed [COORD_W-1:0] cx,
                                                         logic signed [COORD_W-1:0] cy,
                                                         logic signed [COORD_W-1:0] cz);
    lattice_t          ax;
    lattice_t          ay;
    lattice_t          az;
    logic [TBL_AW-1:0] a;
    logic [TBL_AW-1:0] b;
    logic [TBL_AW-1:0] aa;
    logic [TBL_AW-1:0] ab;
    logic [TBL_AW-1:0] ba;
    logic [TBL_AW-1:0] bb;
    longint            x;
    longint            y;
    longint            z;
    longint            x1;
    longint            y1;
    longint            z1;
    longint            n0;
    longint            n1;
    longint            v;
    ax = split_axis(cx);
    ay = split_axis(cy);
    az = split_axis(cz);
    x  = ax.frac;
    y  = ay.frac;
    z  = az.frac;
    x1 = x - ONE_Q16;
    y1 = y - ONE_Q16;
    z1 = z - ONE_Q16;
    if (dims_q <= 2'd1) begin
      // 1D, and dimensions zero: no y or z offsets
      v = lerp_q16(grad_term(perm(ax.base), x, 0, 0),
                   grad_term(perm(ax.base + 8'd1), x1, 0, 0), ax.fade);
    end else begin
      a = perm(ax.base) + ay.base;
      b = perm(ax.base + 8'd1) + ay.base;
      if (dims_q == 2'd2) begin
        n0 = lerp_q16(grad_term(perm(a), x, y, 0), grad_term(perm(b), x1, y, 0), ax.fade);
        n1 = lerp_q16(grad_term(perm(a + 8'd1), x, y1, 0),
                      grad_term(perm(b + 8'd1), x1, y1, 0), ax.fade);
        v  = lerp_q16(n0, n1, ay.fade);
      end else begin
        aa = perm(a) + az.base;
        ab = perm(a + 8'd1) + az.base;
        ba = perm(b) + az.base;
        bb = perm(b + 8'd1) + az.base;
        n0 = lerp_q16(
               lerp_q16(grad_term(perm(aa), x, y, z), grad_term(perm(ba), x1, y, z), ax.fade),
               lerp_q16(grad_term(perm(ab), x, y1, z), grad_term(perm(bb), x1, y1, z),
                        ax.fade),
               ay.fade);
        n1 = lerp_q16(
               lerp_q16(grad_term(perm(aa + 8'd1), x, y, z1),
                        grad_term(perm(ba + 8'd1), x1, y, z1), ax.fade),
               lerp_q16(grad_term(perm(ab + 8'd1), x, y1, z1),
                        grad_term(perm(bb + 8'd1), x1, y1, z1), ax.fade),
               ay.fade);
        v  = lerp_q16(n0, n1, az.fade);
      end
    end
    if (unit_q) v = (v >>> 1) + 32768;
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[NOISE_W-1:0];
  endfunction

  function automatic stim_row_t make_load(logic [INDEX_W-1:0] idx, logic [ENTRY_W-1:0] val);
    stim_row_t r;
    r          = '0;
    r.mode     = MODE_LOAD;
    r.idx      = idx;
    r.val      = val;
    r.x        = $urandom;
    r.y        = $urandom;
    r.z        = $urandom;
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom;
    if (pick < 8) return int'($urandom_range(0, 2097151)) - 1048576;
    if (pick == 8) begin
      case ($urandom_range(0, 3))
        0: return 32'h80000000;
        1: return 32'h7FFFFFFF;
        2: return 32'h0;
        default: return 32'hFFFFFFFF;
      endcase
    end
    return (int'($urandom_range(0, 64)) - 32) * ONE_Q16;
  endfunction

  function automatic stim_row_t random_item();
    stim_row_t r;
    if ($urandom_range(0, 9) < 3) begin
      r = make_load($urandom, $urandom);
    end else begin
      r          = '0;
      r.mode     = MODE_POINT;
      r.idx      = $urandom;
      r.val      = $urandom;
      r.x        = random_coord();
      r.y        = random_coord();
      r.z        = random_coord();
    end
    return r;
  endfunction

  // Hold the transaction until accepted, then record what it should produce
  task automatic offer(input stim_row_t r);
    in_valid    <= 1'b1;
    mode        <= r.mode;
    table_index <= r.idx;
    table_value <= r.val;
    coord_x     <= r.x;
    coord_y     <= r.y;
    coord_z     <= r.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.mode == MODE_LOAD) shadow_perm[r.idx] = r.val;
    else noise_due.push_back(r.has_want ? r.want : noise_at(r.x, r.y, r.z));
  endtask

  task automatic sender_pause();
    int gap;
    if (calm) return;
    if (free_items > 0) begin
      free_items--;
    end else if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      free_items = $urandom_range(1, 25);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (noise_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (which)
      REG_FREQUENCY:  freq_q = data;
      REG_SEED_BITS:  seed_q = data[3:0];
      REG_DIMENSIONS: dims_q = data[1:0];
      default:        unit_q = data[0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Output side: random stall bursts, one long hold-off on request
  initial begin
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        out_stall <= 1'b0;
      end else if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        out_stall <= 1'b0;
        free_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 18);
        else if ($urandom_range(0, 5) == 0) free_left = $urandom_range(60, 150);
        else free_left = $urandom_range(1, 30);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (noise_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected noise result %0d", noise_value);
      end else begin
        due_head = noise_due.pop_front();
        if (noise_value !== due_head) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("noise mismatch: expected %0d got %0d", due_head, noise_value);
        end
      end
    end
  end

  initial begin
    phase_setup_t ps;
    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = MODE_LOAD;
    table_index = '0;
    table_value = '0;
    coord_x     = '0;
    coord_y     = '0;
    coord_z     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_FREQUENCY;
    cfg_data    = '0;
    freq_q      = 24'd65536;
    seed_q      = 4'd0;
    dims_q      = 2'd3;
    unit_q      = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every entry first so no point reads an unwritten one
    for (int i = 0; i < TABLE_SIZE; i++) begin
      offer(make_load(i, $urandom));
      sender_pause();
    end

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer(DIRECTED[i]);
      sender_pause();
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      ps = PHASE_SETUP[p];
      if (ps.roll) begin
        ps.freq = $urandom_range(0, 1) ? $urandom_range(0, 24'h3FFFF)
                                       : $urandom_range(0, 24'hFFFFFF);
        ps.seed = $urandom;
      end
      if (p == NUM_PHASES - 1) calm = 1'b1;
      write_reg(REG_FREQUENCY, ps.freq);
      write_reg(REG_SEED_BITS, CFG_DW'(ps.seed));
      write_reg(REG_DIMENSIONS, CFG_DW'(ps.dims));
      write_reg(REG_UNIT_RANGE, CFG_DW'(ps.unit));
      // Back up the output so the block stalls its input
      if (p == 0) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) settle();
        offer(random_item());
        sender_pause();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // The slowest correct run ends well before this timeout
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
